@@ design/kwh_pkg.sv @@
package kwh_pkg;

    localparam int DEF_MAX_WORD_LEN = 8;
    localparam int DEF_NUM_KEYWORDS = 6;

    localparam int KEY_W       = 64;
    localparam int KEY_BYTES   = KEY_W / 8;
    localparam int LEN_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOLD_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_0 = 3'd1;

    localparam logic [7:0] ESC_BYTE     = 8'h1b;
    localparam logic [7:0] LBRACKET     = 8'h5b;
    localparam logic [7:0] CHAR_BOLD    = 8'h31;
    localparam logic [7:0] CHAR_ULINE   = 8'h34;
    localparam logic [7:0] CHAR_M       = 8'h6d;

    // one flush job for the output side
    typedef struct packed {
        logic [KEY_W-1:0] word;     // buffered letters, first in low byte
        logic [LEN_W-1:0] len;      // number of letters to emit
        logic             hit;      // wrap word in escapes
        logic             bold;
        logic             has_tail; // trailing byte follows the word
        logic [7:0]       tail;
    } t_cmd;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

endpackage

@@ design/kwh_front.sv @@
module kwh_front #(
    parameter int MAX_WORD_LEN = kwh_pkg::DEF_MAX_WORD_LEN,
    parameter int NUM_KEYWORDS = kwh_pkg::DEF_NUM_KEYWORDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [kwh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kwh_pkg::KEY_W-1:0]      i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_byte,
    input  logic                           i_eot,
    input  logic                           i_q_full,
    output logic                           o_push,
    output kwh_pkg::t_cmd                  o_cmd
);
    import kwh_pkg::*;

    localparam int IdxW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

    logic [7:0]       r_buf [MAX_WORD_LEN];
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;
    logic             r_bold;
    logic [KEY_W-1:0] r_kw [NUM_KEYWORDS];

    logic [KEY_W-1:0] packed_word;
    logic             hit;
    logic             accept;
    logic             letter;
    logic             buf_wr;

    always_comb begin
        packed_word = '0;
        for (int i = 0; i < MAX_WORD_LEN; i++) begin
            if (LEN_W'(i) < r_len) begin
                packed_word[8*i +: 8] = r_buf[i];
            end
        end
    end

    always_comb begin
        hit = 1'b0;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (r_kw[k] != '0 && r_kw[k] == packed_word) begin
                hit = 1'b1;
            end
        end
        if (r_len == '0) begin
            hit = 1'b0;
        end
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign letter  = is_letter(i_byte);

    always_comb begin
        o_cmd.word     = packed_word;
        o_cmd.len      = r_len;
        o_cmd.hit      = 1'b0;
        o_cmd.bold     = r_bold;
        o_cmd.has_tail = 1'b0;
        o_cmd.tail     = i_byte;
        o_push         = 1'b0;
        buf_wr         = 1'b0;
        n_len          = r_len;
        n_ovf          = r_ovf;
        if (accept) begin
            priority if (i_eot) begin
                o_push    = r_len != '0;
                o_cmd.hit = hit;
                n_len     = '0;
                n_ovf     = 1'b0;
            end else if (letter && r_ovf) begin
                o_push         = 1'b1;
                o_cmd.len      = '0;
                o_cmd.has_tail = 1'b1;
            end else if (letter && r_len < LEN_W'(MAX_WORD_LEN)) begin
                buf_wr = 1'b1;
                n_len  = r_len + 1'b1;
            end else if (letter) begin
                // word too long: dump it unmatched, pass the rest through
                o_push         = 1'b1;
                o_cmd.has_tail = 1'b1;
                n_len          = '0;
                n_ovf          = 1'b1;
            end else begin
                o_push         = 1'b1;
                o_cmd.hit      = hit;
                o_cmd.has_tail = 1'b1;
                n_len          = '0;
                n_ovf          = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_wr) begin
            r_buf[r_len[IdxW-1:0]] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_bold <= 1'b1;
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                r_kw[k] <= '0;
            end
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
            if (i_cfg_wr_en && i_cfg_index == CFG_BOLD_MODE) begin
                r_bold <= i_cfg_wdata[0];
            end
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                if (i_cfg_wr_en && i_cfg_index == CFG_KEYWORD_0 + CFG_IDX_W'(k)) begin
                    r_kw[k] <= i_cfg_wdata;
                end
            end
        end
    end

endmodule

@@ design/kwh_queue.sv @@
module kwh_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kwh_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output kwh_pkg::t_cmd o_cmd
);
    import kwh_pkg::*;

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_count == CntW'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CntW'(do_push) - CntW'(do_pop);
        end
    end

endmodule

@@ design/kwh_back.sv @@
module kwh_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  kwh_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_tvalid,
    input  logic          i_tready,
    output logic [7:0]    o_tdata,
    output logic          o_tlast
);
    import kwh_pkg::*;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_WORD  = 2'd1;
    localparam logic [1:0] PH_END   = 2'd2;
    localparam logic [1:0] PH_TAIL  = 2'd3;

    localparam int WIdxW = $clog2(KEY_BYTES);

    t_cmd             r_cmd;
    logic             r_busy, n_busy;
    logic [1:0]       r_phase, n_phase;
    logic [1:0]       r_sub, n_sub;
    logic [WIdxW-1:0] r_widx, n_widx;
    logic [LEN_W-1:0] r_left, n_left;
    logic             r_ov;
    logic [7:0]       r_data;
    logic             r_last;

    logic             emit;
    logic [7:0]       cur_byte;
    logic             done;

    assign o_pop    = !r_busy && i_q_valid;
    assign emit     = r_busy && (!r_ov || i_tready);
    assign o_tvalid = r_ov;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

    always_comb begin
        unique case (r_phase)
            PH_START: begin
                unique case (r_sub)
                    2'd0:    cur_byte = ESC_BYTE;
                    2'd1:    cur_byte = LBRACKET;
                    2'd2:    cur_byte = r_cmd.bold ? CHAR_BOLD : CHAR_ULINE;
                    default: cur_byte = CHAR_M;
                endcase
            end
            PH_WORD: cur_byte = r_cmd.word[8*r_widx +: 8];
            PH_END: begin
                unique case (r_sub)
                    2'd0:    cur_byte = ESC_BYTE;
                    2'd1:    cur_byte = LBRACKET;
                    default: cur_byte = CHAR_M;
                endcase
            end
            default: cur_byte = r_cmd.tail;
        endcase
    end

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_sub   = r_sub;
        n_widx  = r_widx;
        n_left  = r_left;
        done    = 1'b0;
        if (o_pop) begin
            n_busy = 1'b1;
            n_sub  = '0;
            n_widx = '0;
            n_left = i_cmd.len;
            priority if (i_cmd.hit) begin
                n_phase = PH_START;
            end else if (i_cmd.len != '0) begin
                n_phase = PH_WORD;
            end else begin
                n_phase = PH_TAIL;
            end
        end else if (emit) begin
            unique case (r_phase)
                PH_START: begin
                    n_sub = r_sub + 1'b1;
                    if (r_sub == 2'd3) begin
                        n_phase = PH_WORD;
                    end
                end
                PH_WORD: begin
                    n_widx = r_widx + 1'b1;
                    n_left = r_left - 1'b1;
                    if (r_left == LEN_W'(1)) begin
                        priority if (r_cmd.hit) begin
                            n_phase = PH_END;
                            n_sub   = '0;
                        end else if (r_cmd.has_tail) begin
                            n_phase = PH_TAIL;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                PH_END: begin
                    n_sub = r_sub + 1'b1;
                    if (r_sub == 2'd2) begin
                        if (r_cmd.has_tail) begin
                            n_phase = PH_TAIL;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                default: done = 1'b1;
            endcase
            if (done) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_data <= cur_byte;
            r_last <= done;
        end
        r_phase <= n_phase;
        r_sub   <= n_sub;
        r_widx  <= n_widx;
        r_left  <= n_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

@@ design/keyword_highlight_filter.sv @@
// Keyword highlighter for a text byte stream. Letters are held back as a word of
// up to MAX_WORD_LEN bytes; a non-letter byte or a request with tlast set ends the
// word. A word equal to one of the NUM_KEYWORDS nonzero keyword registers goes out
// as ESC[1m (or ESC[4m with bold_mode clear), the word, ESC[m; other words go out
// unchanged, then the non-letter byte. A tlast request carries no byte. Longer
// words are passed through unmatched up to the next non-letter. o_m_axis_tlast
// marks the last byte caused by one input request. Every request that produces
// output turns into one job in a two-entry queue; the output sequencer loads each
// job and then drains it at one byte per cycle while the output is not stalled, so
// a flush carries up to 16 bytes and the sustained rate is set by the output side.
// Input stalls only while the queue is full. Keyword registers: index 0 is
// bold_mode, 1..6 are keyword_0..keyword_5.
module keyword_highlight_filter #(
    parameter int MAX_WORD_LEN = kwh_pkg::DEF_MAX_WORD_LEN,
    parameter int NUM_KEYWORDS = kwh_pkg::DEF_NUM_KEYWORDS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [kwh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kwh_pkg::KEY_W-1:0]     i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // [7:0] in_byte
    input  logic                          i_s_axis_tlast,  // end_of_text
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,  // [7:0] out_byte
    output logic                          o_m_axis_tlast   // last_of_run
);
    import kwh_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    kwh_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .NUM_KEYWORDS (NUM_KEYWORDS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .i_eot       (i_s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    kwh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (queue_cmd)
    );

    kwh_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (queue_cmd),
        .o_pop     (pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tlast   (o_m_axis_tlast)
    );

endmodule

@@ sim/keyword_highlight_checker.sv @@
// Watches the config port and both stream channels, predicts the filtered
// output for every accepted request and compares it byte by byte.
module keyword_highlight_checker #(
    parameter int MAX_LEN = kwh_pkg::DEF_MAX_WORD_LEN,
    parameter int N_KEYS  = kwh_pkg::DEF_NUM_KEYWORDS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [kwh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kwh_pkg::KEY_W-1:0]     i_cfg_wdata,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [7:0]                    i_s_tdata,
    input  logic                          i_s_tlast,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [7:0]                    i_m_tdata,
    input  logic                          i_m_tlast,
    output int                            o_err_count,
    output int                            o_pending,
    output int                            o_result_count,
    output int                            o_hit_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_byte;

    t_text_byte               text_q[$];
    logic                     bold_shadow;
    logic [kwh_pkg::KEY_W-1:0] key_shadow[N_KEYS];
    logic [7:0]               word_bytes[MAX_LEN];
    int                       word_len;
    logic                     long_word;

    int err_count     = 0;
    int pending_count = 0;
    int result_count  = 0;
    int hit_count     = 0;

    assign o_err_count    = err_count;
    assign o_pending      = pending_count;
    assign o_result_count = result_count;
    assign o_hit_count    = hit_count;

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
    endfunction

    function automatic bit word_is_key();
        logic [kwh_pkg::KEY_W-1:0] word_bits;
        bit                        hit;
        word_bits = '0;
        hit       = 1'b0;
        for (int i = 0; i < word_len; i++) begin
            word_bits[8*i +: 8] = word_bytes[i];
        end
        // zero slots are unused and never match
        for (int k = 0; k < N_KEYS; k++) begin
            if (key_shadow[k] != '0 && key_shadow[k] == word_bits) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (err_count < 20) begin
            $display("[%0t] mismatch, %s: got %02h, expected %02h", $time, what, got, want);
        end
        err_count++;
    endtask

    // Work out the output bytes caused by one request and queue them.
    task automatic filter_step(input logic [7:0] b, input logic eot);
        logic [7:0] run[$];
        t_text_byte e;
        bit         hit;
        if (eot || !is_alpha(b)) begin
            if (word_len > 0) begin
                hit = word_is_key();
                if (hit) begin
                    run.push_back(kwh_pkg::ESC_BYTE);
                    run.push_back(kwh_pkg::LBRACKET);
                    run.push_back(bold_shadow ? kwh_pkg::CHAR_BOLD : kwh_pkg::CHAR_ULINE);
                    run.push_back(kwh_pkg::CHAR_M);
                    hit_count++;
                end
                for (int i = 0; i < word_len; i++) begin
                    run.push_back(word_bytes[i]);
                end
                if (hit) begin
                    run.push_back(kwh_pkg::ESC_BYTE);
                    run.push_back(kwh_pkg::LBRACKET);
                    run.push_back(kwh_pkg::CHAR_M);
                end
                word_len = 0;
            end
            long_word = 1'b0;
            if (!eot) begin
                run.push_back(b);
            end
        end else if (long_word) begin
            run.push_back(b);
        end else if (word_len < MAX_LEN) begin
            word_bytes[word_len] = b;
            word_len++;
        end else begin
            // word too long for the buffer: dump it and pass the rest through
            for (int i = 0; i < word_len; i++) begin
                run.push_back(word_bytes[i]);
            end
            run.push_back(b);
            word_len  = 0;
            long_word = 1'b1;
        end
        for (int i = 0; i < run.size(); i++) begin
            e.data = run[i];
            e.last = (i == run.size() - 1);
            text_q.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_text_byte want;
        if (!i_rst_n) begin
            text_q.delete();
            bold_shadow = 1'b1;
            for (int k = 0; k < N_KEYS; k++) begin
                key_shadow[k] = '0;
            end
            word_len  = 0;
            long_word = 1'b0;
        end else begin
            // an output can never stem from a request taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                result_count++;
                if (text_q.size() == 0) begin
                    report_mismatch("byte with nothing expected", i_m_tdata, 8'h00);
                end else begin
                    want = text_q.pop_front();
                    if (i_m_tdata !== want.data) begin
                        report_mismatch("out_byte", i_m_tdata, want.data);
                    end
                    if (i_m_tlast !== want.last) begin
                        report_mismatch("last_of_run", {7'd0, i_m_tlast}, {7'd0, want.last});
                    end
                end
            end
            if (i_cfg_wr_en) begin
                if (i_cfg_index == kwh_pkg::CFG_BOLD_MODE) begin
                    bold_shadow = i_cfg_wdata[0];
                end else if (i_cfg_index >= kwh_pkg::CFG_KEYWORD_0 &&
                             i_cfg_index < kwh_pkg::CFG_KEYWORD_0 + N_KEYS) begin
                    key_shadow[i_cfg_index - kwh_pkg::CFG_KEYWORD_0] = i_cfg_wdata;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                filter_step(i_s_tdata, i_s_tlast);
            end
        end
        pending_count = text_q.size();
    end

endmodule

@@ sim/keyword_highlight_filter_tb.sv @@
module keyword_highlight_filter_tb;

    localparam int N_KEYS       = kwh_pkg::DEF_NUM_KEYWORDS;
    localparam int IDX_W        = kwh_pkg::CFG_IDX_W;
    localparam int PHASE_ITEMS  = 45;
    localparam int SETTLE       = 40;
    localparam int IDLE_LIMIT   = 3000;
    // index past the last keyword; writes there must change nothing
    localparam logic [kwh_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [7:0] SPACE = 8'h20;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [kwh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [kwh_pkg::KEY_W-1:0]     cfg_wdata = '0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic [7:0]                    s_data    = 8'h00;
    logic                          s_last    = 1'b0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic [7:0]                    m_data;
    logic                          m_last;

    int  err_count, pending, result_count, hit_count;
    int  requests_sent = 0;
    int  settings_used = 0;
    int  idle_cycles   = 0;
    int  m_stall_left  = 0;
    bit  s_gaps_on     = 1'b1;
    bit  m_stalls_on   = 1'b1;

    always #5 clk = ~clk;

    keyword_highlight_filter dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tlast (m_last)
    );

    keyword_highlight_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_s_tlast     (s_last),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .i_m_tlast     (m_last),
        .o_err_count   (err_count),
        .o_pending     (pending),
        .o_result_count(result_count),
        .o_hit_count   (hit_count)
    );

    // mostly no gap, sometimes a few cycles, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 6);
    endfunction

    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 8; i++) begin
            v[8*i +: 8] = s[i];
        end
        return v;
    endfunction

    function automatic string vocab_word(input int k);
        case (k)
            0:       return "if";
            1:       return "while";
            2:       return "A";
            3:       return "z";
            4:       return "ABCDEFGH";
            5:       return "return";
            6:       return "Zebra";
            7:       return "int";
            8:       return "yzYZabAB";
            default: return "for";
        endcase
    endfunction

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(9))
            0:       return 8'h41;
            1:       return 8'h5a;
            2:       return 8'h61;
            3:       return 8'h7a;
            4, 5, 6: return 8'h41 + 8'($urandom_range(25));
            default: return 8'h61 + 8'($urandom_range(25));
        endcase
    endfunction

    function automatic logic [7:0] rand_separator();
        logic [7:0] b;
        case ($urandom_range(9))
            0: return 8'h40;
            1: return 8'h5b;
            2: return 8'h60;
            3: return 8'h7b;
            4: return 8'h00;
            5: return 8'hff;
            default: begin
                b = 8'($urandom_range(255));
                while ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a)) begin
                    b = 8'($urandom_range(255));
                end
                return b;
            end
        endcase
    endfunction

    // output side back-pressure
    always @(negedge clk) begin
        if (!m_stalls_on) begin
            m_ready <= 1'b1;
        end else if (m_stall_left > 0) begin
            m_stall_left = m_stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_stall_left = pick_gap();
            m_ready <= (m_stall_left == 0);
            if (m_stall_left > 0) begin
                m_stall_left = m_stall_left - 1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[%0t] no traffic for %0d cycles, %0d bytes still expected",
                         $time, IDLE_LIMIT, pending);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Valid stays high between back-to-back requests; it drops only for a gap.
    task automatic send_req(input logic [7:0] b, input logic eot);
        int gap;
        gap = s_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eot;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_req(s[i], 1'b0);
        end
    endtask

    task automatic send_letters(input int len);
        for (int i = 0; i < len; i++) begin
            send_req(rand_letter(), 1'b0);
        end
    endtask

    task automatic apply_settings(input logic bold, input logic [63:0] keys[N_KEYS]);
        cfg_wr_en <= 1'b1;
        cfg_index <= kwh_pkg::CFG_BOLD_MODE;
        cfg_wdata <= {$urandom, 31'd0, bold};
        @(negedge clk);
        for (int k = 0; k < N_KEYS; k++) begin
            cfg_index <= kwh_pkg::CFG_KEYWORD_0 + IDX_W'(k);
            cfg_wdata <= keys[k];
            @(negedge clk);
        end
        cfg_index <= CFG_SPARE;
        cfg_wdata <= {$urandom, $urandom};
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // drop valid, let all expected bytes drain, then give the block time to settle
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic random_settings(input logic [63:0] keys[N_KEYS], output logic bold,
                                   output logic [63:0] picked[N_KEYS]);
        bold = 1'($urandom_range(1));
        for (int k = 0; k < N_KEYS; k++) begin
            case ($urandom_range(9))
                6:       picked[k] = '0;
                7:       picked[k] = {$urandom, $urandom};
                8:       picked[k] = '1;
                9:       picked[k] = keys[k];
                default: picked[k] = pack_text(vocab_word($urandom_range(9)));
            endcase
        end
    endtask

    // Mostly words and separators, some too-long words, some raw bytes.
    task automatic random_text(input int n_items);
        int first;
        int r;
        first = requests_sent;
        s_gaps_on   = $urandom_range(3) != 0;
        m_stalls_on = $urandom_range(3) != 0;
        while (requests_sent - first < n_items) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_text(vocab_word($urandom_range(9)));
            end else if (r < 75) begin
                send_letters($urandom_range(8, 1));
            end else if (r < 85) begin
                send_letters($urandom_range(13, 9));
            end else begin
                send_req(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            r = $urandom_range(9);
            if (r == 0) begin
                send_req(8'($urandom_range(255)), 1'b1);
            end else if (r < 9) begin
                send_req(rand_separator(), 1'b0);
            end
            // r == 9: no separator, the next word runs on
        end
        send_req(8'($urandom_range(255)), 1'b1);
        s_gaps_on   = 1'b1;
        m_stalls_on = 1'b1;
    endtask

    initial begin : stimulus
        logic [63:0] keys[N_KEYS];
        logic [63:0] next_keys[N_KEYS];
        logic        bold;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: matches at both length extremes, keywords that cannot match
        keys[0] = pack_text("if");
        keys[1] = pack_text("while");
        keys[2] = pack_text("ABCDEFGH");
        keys[3] = pack_text("a");
        keys[4] = 64'h0000_0000_0062_0061;  // inner zero byte
        keys[5] = '1;                       // not letters
        apply_settings(1'b1, keys);
        send_text("if");
        send_req(8'h00, 1'b1);              // word flushed by end of text
        send_text("ABCDEFGH");
        send_req(8'h7b, 1'b0);              // longest flush: 16 bytes
        send_req(8'hff, 1'b1);              // end of text with nothing pending
        send_text("a");
        send_req(8'h00, 1'b0);
        send_text("abcdefghi");             // one letter past the buffer
        send_req(8'hff, 1'b0);
        drain();

        // underline start escape, all slots taken by plain keywords
        for (int k = 0; k < N_KEYS; k++) begin
            keys[k] = pack_text(vocab_word(k));
        end
        apply_settings(1'b0, keys);
        random_text(PHASE_ITEMS);
        drain();

        repeat (2) begin
            random_settings(keys, bold, next_keys);
            keys = next_keys;
            apply_settings(bold, keys);
            random_text(PHASE_ITEMS);
            drain();
        end

        // extremes: empty and all-ones slots beside a few live ones
        keys[0] = '0;
        keys[1] = '1;
        keys[2] = pack_text("yzYZabAB");
        keys[3] = pack_text("A");
        keys[4] = '0;
        keys[5] = pack_text("Zebra");
        apply_settings(1'b1, keys);
        random_text(PHASE_ITEMS);
        drain();

        $display("Sent %0d input requests under %0d keyword settings, bold and underline.",
                 requests_sent, settings_used);
        $display("Checked %0d output bytes, %0d of the flushed words highlighted.",
                 result_count, hit_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
